// ===== hdl/fmr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and handshake structs for the fraction multiply and reduce block.
// No dependencies; imported by fmr_div, fraction_multiply_reduce, both checkers and the bench.
package fmr_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int RES_W         = 32;
	localparam int IN_W          = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
	localparam int OUT_W         = 2 * RES_W;
	localparam int CNT_W         = $clog2(PROD_W + 1);

	typedef logic signed [OPERAND_WIDTH-1:0] opnd_t;
	typedef logic signed [PROD_W-1:0]        prod_t;
	typedef logic signed [RES_W-1:0]         res_t;

	typedef struct packed {
		logic  start;
		prod_t dividend;
		prod_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		prod_t quot;
		prod_t rem;
	} div_rsp_t;

endpackage

// ===== hdl/fmr_div.sv =====
`timescale 1ns / 1ps
// Bit-serial signed divider with truncating quotient and remainder, one bit per cycle.
// Depends on fmr_pkg for widths and the request/response structs.
module fmr_div
	import fmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q_q;
	logic              neg_r_q;
	logic [PROD_W-1:0] b_q;
	logic [PROD_W-1:0] quo_q;
	logic [PROD_W-1:0] rem_q;

	prod_t             dvd_abs;
	prod_t             dvs_abs;
	logic [PROD_W:0]   partial;
	logic [PROD_W:0]   diff;

	assign dvd_abs = req.dividend[PROD_W-1] ? -req.dividend : req.dividend;
	assign dvs_abs = req.divisor[PROD_W-1]  ? -req.divisor  : req.divisor;
	assign partial = {rem_q, quo_q[PROD_W-1]};
	assign diff    = partial - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q_q <= req.dividend[PROD_W-1] ^ req.divisor[PROD_W-1];
			neg_r_q <= req.dividend[PROD_W-1];
			b_q     <= dvs_abs;
			quo_q   <= dvd_abs;
			rem_q   <= '0;
		end else if (busy_q) begin
			// restoring step: keep the difference when it does not go negative
			if (!diff[PROD_W]) begin
				rem_q <= diff[PROD_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= partial[PROD_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q_q ? -prod_t'(quo_q) : prod_t'(quo_q);
	assign rsp.rem  = neg_r_q ? -prod_t'(rem_q) : prod_t'(rem_q);

endmodule

// ===== hdl/fraction_multiply_reduce.sv =====
`timescale 1ns / 1ps
// Multiplies two signed fractions and reduces the result by a Euclid divisor.
// Depends on fmr_pkg and fmr_div.

// One item is taken at a time: s_tready is high only while the block is idle.
// After a beat is accepted the block forms the products, then runs Euclid's algorithm
// and the two final divisions on a single bit-serial divider; each Euclid remainder
// step passes back through the loop state. When both products are zero the result
// is 0/0 with m_tuser set. A finished result sits in the output register until
// taken; a new item may be accepted meanwhile, and its result waits for the
// register to free up.
module fraction_multiply_reduce
	import fmr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // a_num, a_den, b_num, b_den
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // res_num, res_den
	output logic             m_tuser   // zero_divisor
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_EUCLID,
		S_EWAIT,
		S_QNUM,
		S_QDEN,
		S_DONE
	} state_t;

	state_t   state_q;
	opnd_t    a_num_q, a_den_q, b_num_q, b_den_q;
	prod_t    pn_q, pd_q, m_q, n_q;
	res_t     rn_q, rd_q;
	logic     flag_q;
	logic     start_q;
	prod_t    dvd_q, dvs_q;
	res_t     res_num_q, res_den_q;
	logic     out_flag_q;
	logic     out_valid_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start    = start_q;
	assign div_req.dividend = dvd_q;
	assign div_req.divisor  = dvs_q;

	fmr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// kick the divider for a Euclid step, the numerator and the denominator
			start_q <= ((state_q == S_EUCLID) && ((n_q != '0) || (m_q != '0)))
				|| ((state_q == S_QNUM) && div_rsp.done);
			if ((state_q == S_DONE) && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_EUCLID;
				end
				S_EUCLID: begin
					if (n_q != '0)
						state_q <= S_EWAIT;
					else if (m_q == '0)
						state_q <= S_DONE;
					else
						state_q <= S_QNUM;
				end
				S_EWAIT: begin
					if (div_rsp.done)
						state_q <= S_EUCLID;
				end
				S_QNUM: begin
					if (div_rsp.done)
						state_q <= S_QDEN;
				end
				S_QDEN: begin
					if (div_rsp.done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || m_tready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				a_num_q <= s_tdata[0*OPERAND_WIDTH +: OPERAND_WIDTH];
				a_den_q <= s_tdata[1*OPERAND_WIDTH +: OPERAND_WIDTH];
				b_num_q <= s_tdata[2*OPERAND_WIDTH +: OPERAND_WIDTH];
				b_den_q <= s_tdata[3*OPERAND_WIDTH +: OPERAND_WIDTH];
			end
			S_MUL: begin
				pn_q <= a_num_q * b_num_q;
				pd_q <= a_den_q * b_den_q;
				m_q  <= a_num_q * b_num_q;
				n_q  <= a_den_q * b_den_q;
			end
			S_EUCLID: begin
				if (n_q != '0) begin
					dvd_q <= m_q;
					dvs_q <= n_q;
				end else if (m_q == '0) begin
					rn_q   <= '0;
					rd_q   <= '0;
					flag_q <= 1'b1;
				end else begin
					dvd_q  <= pn_q;
					dvs_q  <= m_q;
					flag_q <= 1'b0;
				end
			end
			S_EWAIT: begin
				if (div_rsp.done) begin
					m_q <= n_q;
					n_q <= div_rsp.rem;
				end
			end
			S_QNUM: begin
				if (div_rsp.done) begin
					rn_q  <= RES_W'(div_rsp.quot);
					dvd_q <= pd_q;
				end
			end
			S_QDEN: begin
				if (div_rsp.done)
					rd_q <= RES_W'(div_rsp.quot);
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					res_num_q  <= rn_q;
					res_den_q  <= rd_q;
					out_flag_q <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_den_q, res_num_q};
	assign m_tuser  = out_flag_q;

endmodule

// ===== hdl/fmr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for fraction_multiply_reduce, bound to the top level.
// Depends on fmr_pkg for the port widths.
module fmr_port_checks
	import fmr_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// an accepted item keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// a zero divisor always reports 0/0
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero divisor with nonzero result");

	// a valid divisor leaves at least one nonzero term
	a_nonzero_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata != '0)
		else $error("reduced fraction is 0/0 without flag");

endmodule

bind fraction_multiply_reduce fmr_port_checks u_fmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== bench/fmr_checker.sv =====
`timescale 1ns / 1ps
// Checks the fraction multiply and reduce block: predicts each reduced fraction and matches results.
// Depends on fmr_pkg; instantiated by tb_fraction_multiply_reduce next to the block.
module fmr_checker
	import fmr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // a_num, a_den, b_num, b_den
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,  // res_num, res_den
	input  logic             m_tuser,  // zero_divisor
	output int               errors,
	output int               outstanding,
	output int               checked,
	output int               zero_results
);

	typedef struct {
		res_t num;
		res_t den;
		logic zero_div;
	} fraction_t;

	fraction_t reduced_q[$];

	// Euclid on the two products with truncating remainder; the divisor keeps its sign.
	function automatic fraction_t reduce_product(input opnd_t an, input opnd_t ad,
		input opnd_t bn, input opnd_t bd);
		longint num_prod;
		longint den_prod;
		longint m;
		longint n;
		longint rem;
		fraction_t f;
		num_prod = longint'(an) * longint'(bn);
		den_prod = longint'(ad) * longint'(bd);
		m = num_prod;
		n = den_prod;
		while (n != 0) begin
			rem = m % n;
			m = n;
			n = rem;
		end
		if (m == 0) begin
			f.num = '0;
			f.den = '0;
			f.zero_div = 1'b1;
		end else begin
			f.num = res_t'(num_prod / m);
			f.den = res_t'(den_prod / m);
			f.zero_div = 1'b0;
		end
		return f;
	endfunction

	always @(posedge clk) begin : watch
		fraction_t want;
		res_t got_num;
		res_t got_den;
		if (arst_n) begin
			// retire the result first: a beat accepted at this edge cannot finish at it
			if (m_tvalid && m_tready) begin
				got_num = m_tdata[RES_W-1:0];
				got_den = m_tdata[2*RES_W-1:RES_W];
				if (reduced_q.size() == 0) begin
					$error("result beat %0d/%0d arrived with no fraction outstanding",
						got_num, got_den);
					errors++;
				end else begin
					want = reduced_q.pop_front();
					if (got_num !== want.num) begin
						$error("res_num: expected %0d, got %0d", want.num, got_num);
						errors++;
					end
					if (got_den !== want.den) begin
						$error("res_den: expected %0d, got %0d", want.den, got_den);
						errors++;
					end
					if (m_tuser !== want.zero_div) begin
						$error("zero_divisor: expected %0b, got %0b", want.zero_div, m_tuser);
						errors++;
					end
					if (want.zero_div)
						zero_results++;
				end
				checked++;
			end
			if (s_tvalid && s_tready)
				reduced_q.push_back(reduce_product(
					opnd_t'(s_tdata[OPERAND_WIDTH-1:0]),
					opnd_t'(s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
					opnd_t'(s_tdata[3*OPERAND_WIDTH-1:2*OPERAND_WIDTH]),
					opnd_t'(s_tdata[4*OPERAND_WIDTH-1:3*OPERAND_WIDTH])));
			outstanding = reduced_q.size();
		end
	end

endmodule

// ===== bench/tb_fraction_multiply_reduce.sv =====
`timescale 1ns / 1ps
// Top of the fraction multiply and reduce bench: clock, reset, stimulus, sink and verdict.
// Depends on fmr_pkg, fraction_multiply_reduce and fmr_checker.
module tb_fraction_multiply_reduce;
	import fmr_pkg::*;

	localparam int ITEMS_PER_PHASE = 310;
	localparam int HOLD_CYCLES     = 3000;
	localparam int STALL_LIMIT     = 20000;
	localparam int DRAIN_CYCLES    = 40;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	int errors;
	int outstanding;
	int checked;
	int zero_results;
	int src_idle_pct;
	int sink_idle_pct;
	int items_sent;
	int directed_sent;
	int stall_cycles;
	bit hold_req;

	fraction_multiply_reduce dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fmr_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.errors       (errors),
		.outstanding  (outstanding),
		.checked      (checked),
		.zero_results (zero_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one fraction pair and hold it until the block takes the beat.
	task automatic send_fractions(input int an, input int ad, input int bn, input int bd);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {opnd_t'(bd), opnd_t'(bn), opnd_t'(ad), opnd_t'(an)};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Lean toward zeros, extremes and small values so products collide and reduce.
	function automatic int pick_operand();
		case ($urandom_range(15))
			0:       return 0;
			1:       return -32768;
			2:       return 32767;
			3:       return ($urandom_range(1)) ? 1 : -1;
			4, 5, 6: return int'($urandom_range(32)) - 16;
			7, 8:    return int'($urandom_range(255) << $urandom_range(7));
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	// Sink: random backpressure, plus one long hold requested by the stimulus.
	initial begin : sink
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used) begin
				hold_left = HOLD_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		hold_req      = 1'b0;
		items_sent    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero products, one-sided zeros, negative divisors, extremes, bit patterns
		send_fractions(0, 5, 0, 7);
		send_fractions(0, 0, 0, 0);
		send_fractions(3, 0, 4, 0);
		send_fractions(0, -5, 9, 7);
		send_fractions(0, 0, 5, 5);
		send_fractions(5, 3, 0, 0);
		send_fractions(32767, -32768, 0, 1);
		send_fractions(-32768, -32768, -32768, -32768);
		send_fractions(32767, 32767, 32767, 32767);
		send_fractions(-32768, 32767, 32767, -32768);
		send_fractions(-32768, 1, 1, -1);
		send_fractions(1, -32768, -32768, 1);
		send_fractions(1, 1, 1, 1);
		send_fractions(-1, 1, 1, 1);
		send_fractions(6, -4, 10, 9);
		send_fractions(-6, 4, 10, 9);
		send_fractions(-2, -4, 3, -6);
		send_fractions(7, 7, 7, 7);
		send_fractions(12345, -2222, -7777, 31111);
		// alternating bit patterns 0x5555 and 0xaaaa
		send_fractions(21845, -21846, -21846, 21845);
		directed_sent = items_sent;

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 7;
					sink_idle_pct = 76;
				end
				1: begin
					src_idle_pct  = 76;
					sink_idle_pct = 7;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// starve the sink while items keep coming so the input backs up
				if (phase == 2 && i == 0)
					hold_req = 1'b1;
				send_fractions(pick_operand(), pick_operand(), pick_operand(),
					pick_operand());
			end
		end
		s_tvalid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d fraction pairs (%0d directed), %0d results checked, %0d zero-divisor",
			items_sent, directed_sent, checked, zero_results);
		$display("idle mixes: light/heavy sender vs sink, none, plus a %0d-cycle sink hold",
			HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
